/* rtl/rdsa_pkg.sv */
// package for the deduplicating size accumulator: codes, payload types, limits
package rdsa_pkg;

  localparam int KEY_SLOTS_DEF   = 256;
  localparam int ITEM_SLOTS_DEF  = 512;
  localparam int BLOCK_BYTES_DEF = 2048;

  localparam int SIZE_W   = 44;
  localparam int KEY_W    = 64;
  localparam int ID_W     = 32;
  localparam int BYTES_W  = 48;
  localparam int BLOCKS_W = 37;

  localparam logic [BYTES_W-1:0]  BYTES_MAX  = '1;
  localparam logic [BLOCKS_W-1:0] BLOCKS_MAX = '1;

  localparam logic [2:0] OP_ADD_FILE    = 3'd0;
  localparam logic [2:0] OP_RM_FILE     = 3'd1;
  localparam logic [2:0] OP_ADD_SPECIAL = 3'd2;
  localparam logic [2:0] OP_RM_SPECIAL  = 3'd3;
  localparam logic [2:0] OP_CLEAR       = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISSING  = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_KSCAN, S_ISCAN, S_DEC, S_DIV, S_RND, S_TOT, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [ID_W-1:0]   item_id;
    logic [KEY_W-1:0]  inode_key;
    logic [SIZE_W-1:0] item_size;
  } in_item_t;

  typedef struct packed {
    logic [BYTES_W-1:0]  total_bytes;
    logic [BLOCKS_W-1:0] total_blocks;
    logic [1:0]          status;
  } out_item_t;

endpackage

/* rtl/rdsa_ram.sv */
// generic single write port ram with registered read
module rdsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/refcounted_dedup_size_accumulator.sv */
// top level: deduplicating byte and block accumulator with per-key reference counts
//
//  channel | ports                    | transfer
//  --------+--------------------------+--------------------------------------
//  input   | start, busy, in_item     | edge with start high and busy low
//  result  | out_valid, out_result    | one-cycle strobe, receiver cannot stall
//
// flow: a file op scans the key table then the item table, one entry a
//   cycle through the ram read ports; a special op scans only the item table;
//   ops that change the totals then run the shared divider (a reciprocal
//   estimate and a correction for each 16-bit digit of the size), round the
//   quotient up and update the totals
// clear: one sweep over max(KEY_SLOTS, ITEM_SLOTS) addresses writing empty entries
// reset: the same sweep runs after reset with busy high, then the block idles
// unused op codes give one result with status ok
module refcounted_dedup_size_accumulator #(
  parameter int KEY_SLOTS   = rdsa_pkg::KEY_SLOTS_DEF,
  parameter int ITEM_SLOTS  = rdsa_pkg::ITEM_SLOTS_DEF,
  parameter int BLOCK_BYTES = rdsa_pkg::BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rdsa_pkg::in_item_t  in_item,
  output logic                out_valid,
  output rdsa_pkg::out_item_t out_result
);

  localparam int SW   = rdsa_pkg::SIZE_W;
  localparam int KAW  = $clog2(KEY_SLOTS);
  localparam int IAW  = $clog2(ITEM_SLOTS);
  localparam int CW   = $clog2(ITEM_SLOTS + 1);
  localparam int MAXS = (KEY_SLOTS > ITEM_SLOTS) ? KEY_SLOTS : ITEM_SLOTS;
  localparam int SCW  = $clog2(MAXS + 1);
  localparam int KWW  = 1 + rdsa_pkg::KEY_W + CW + SW;
  localparam int IWW  = 2 + rdsa_pkg::ID_W + KAW;
  // divider: 16-bit digits, three of them cover the size
  localparam int DGW  = 16;
  localparam int NDG  = 3;
  localparam int DQW  = DGW * NDG;
  localparam int DCW  = 2;
  localparam int VW   = 2 * DGW;
  localparam int PW   = VW + 33;

  localparam logic [SCW-1:0] KEND = SCW'(KEY_SLOTS);
  localparam logic [SCW-1:0] IEND = SCW'(ITEM_SLOTS);
  localparam logic [SCW-1:0] CEND = SCW'(MAXS - 1);
  localparam logic [DGW:0]   BDIV = (DGW+1)'(BLOCK_BYTES);
  // floor(2^32 / BLOCK_BYTES), estimate is at most one below the true digit
  localparam logic [32:0]    BREC = 33'(64'h1_0000_0000 / 64'(BLOCK_BYTES));

  rdsa_pkg::state_t    state_r, state_nxt;
  rdsa_pkg::in_item_t  req_r, req_nxt;
  rdsa_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SCW-1:0]      cnt_r, cnt_nxt, chk_idx_r, chk_idx_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic                emit_r, emit_nxt;
  logic                kmatch_r, kmatch_nxt, kfree_r, kfree_nxt, ihit_r, ihit_nxt;
  logic [KAW-1:0]      kmatch_idx_r, kmatch_idx_nxt, kfree_idx_r, kfree_idx_nxt;
  logic [IAW-1:0]      ihit_idx_r, ihit_idx_nxt;
  logic [CW-1:0]       kcnt_r, kcnt_nxt;
  logic [SW-1:0]       ksize_r, ksize_nxt;
  logic [1:0]          st_r, st_nxt;
  logic [SW-1:0]       acc_r, acc_nxt;
  logic                sub_r, sub_nxt;
  logic [DQW-1:0]      dq_r, dq_nxt;
  logic [DGW-1:0]      rem_r, rem_nxt;
  logic [DGW-1:0]      qe_r, qe_nxt;
  logic                dph_r, dph_nxt;
  logic [DCW-1:0]      dcnt_r, dcnt_nxt;
  logic [rdsa_pkg::BLOCKS_W-1:0] blk_r, blk_nxt;
  logic [rdsa_pkg::BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [rdsa_pkg::BLOCKS_W-1:0] blocks_r, blocks_nxt;

  // ram ports
  logic           k_we, i_we;
  logic [KAW-1:0] k_waddr, k_raddr;
  logic [IAW-1:0] i_waddr, i_raddr;
  logic [KWW-1:0] k_wdata, k_rdata;
  logic [IWW-1:0] i_wdata, i_rdata;

  // decision after the scans
  logic           dec_kwe, dec_iwe, dec_tot, dec_sub;
  logic [KAW-1:0] dec_kaddr;
  logic [KWW-1:0] dec_kdata;
  logic [IWW-1:0] dec_idata;
  logic [SW-1:0]  dec_acc;
  logic [1:0]     dec_st;
  logic [CW-1:0]  cnt_dec;

  // key word fields: valid, key, ref count, stored size
  logic                       kq_v;
  logic [rdsa_pkg::KEY_W-1:0] kq_key;
  logic [CW-1:0]              kq_cnt;
  logic [SW-1:0]              kq_size;
  // item word fields: valid, special, id, key slot
  logic                       iq_v, iq_sp;
  logic [rdsa_pkg::ID_W-1:0]  iq_id;
  logic [KAW-1:0]             iq_slot;
  logic                       i_cond;

  // divider digit step and total arithmetic
  logic [VW-1:0]  div_v;
  logic [PW-1:0]  div_prod;
  logic [VW:0]    div_qb;
  logic [VW:0]    div_rr;
  logic           div_fix;
  logic [DQW:0]   blk_raw;
  logic [rdsa_pkg::BYTES_W:0]  bsum;
  logic [rdsa_pkg::BLOCKS_W:0] ksum;

  assign kq_v    = k_rdata[KWW-1];
  assign kq_key  = k_rdata[KWW-2 -: rdsa_pkg::KEY_W];
  assign kq_cnt  = k_rdata[SW+CW-1 -: CW];
  assign kq_size = k_rdata[SW-1:0];
  assign iq_v    = i_rdata[IWW-1];
  assign iq_sp   = i_rdata[IWW-2];
  assign iq_id   = i_rdata[IWW-3 -: rdsa_pkg::ID_W];
  assign iq_slot = i_rdata[KAW-1:0];

  rdsa_ram #(.WIDTH(KWW), .DEPTH(KEY_SLOTS)) u_key_ram (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
  );

  rdsa_ram #(.WIDTH(IWW), .DEPTH(ITEM_SLOTS)) u_item_ram (
    .clk, .we(i_we), .waddr(i_waddr), .wdata(i_wdata), .raddr(i_raddr), .rdata(i_rdata)
  );

  // item match rule depends on the op
  always_comb begin
    case (req_r.op)
      rdsa_pkg::OP_ADD_FILE, rdsa_pkg::OP_ADD_SPECIAL: i_cond = !iq_v;
      rdsa_pkg::OP_RM_FILE: i_cond = kmatch_r && iq_v && !iq_sp &&
                                     (iq_id == req_r.item_id) && (iq_slot == kmatch_idx_r);
      rdsa_pkg::OP_RM_SPECIAL: i_cond = iq_v && iq_sp && (iq_id == req_r.item_id);
      default: i_cond = 1'b0;
    endcase
  end

  // what the op does once the scans are in
  always_comb begin
    dec_kwe   = 1'b0;
    dec_iwe   = 1'b0;
    dec_tot   = 1'b0;
    dec_sub   = 1'b0;
    dec_kaddr = kmatch_idx_r;
    dec_kdata = '0;
    dec_idata = '0;
    dec_acc   = req_r.item_size;
    dec_st    = rdsa_pkg::ST_OK;
    cnt_dec   = (kcnt_r == '0) ? '0 : kcnt_r - CW'(1);
    case (req_r.op)
      rdsa_pkg::OP_ADD_FILE: begin
        if (!ihit_r || (!kmatch_r && !kfree_r)) begin
          dec_st = rdsa_pkg::ST_FULL;
        end else begin
          dec_iwe   = 1'b1;
          dec_idata = {1'b1, 1'b0, req_r.item_id, (kmatch_r ? kmatch_idx_r : kfree_idx_r)};
          dec_kwe   = 1'b1;
          if (kmatch_r) begin
            dec_kdata = {1'b1, req_r.inode_key, kcnt_r + CW'(1), ksize_r};
          end else begin
            // first reference stores the size and counts it
            dec_kaddr = kfree_idx_r;
            dec_kdata = {1'b1, req_r.inode_key, CW'(1), req_r.item_size};
            dec_tot   = 1'b1;
          end
        end
      end
      rdsa_pkg::OP_RM_FILE: begin
        if (!ihit_r) begin
          dec_st = rdsa_pkg::ST_MISSING;
        end else begin
          dec_iwe = 1'b1;
          dec_kwe = 1'b1;
          if (req_r.item_size != ksize_r) begin
            dec_st = rdsa_pkg::ST_MISMATCH;
          end
          if (cnt_dec == '0) begin
            // last reference: stored size leaves the totals
            dec_tot = 1'b1;
            dec_sub = 1'b1;
            dec_acc = ksize_r;
          end else begin
            dec_kdata = {1'b1, req_r.inode_key, cnt_dec, ksize_r};
          end
        end
      end
      rdsa_pkg::OP_ADD_SPECIAL: begin
        if (!ihit_r) begin
          dec_st = rdsa_pkg::ST_FULL;
        end else begin
          dec_iwe   = 1'b1;
          dec_idata = {1'b1, 1'b1, req_r.item_id, KAW'(0)};
          dec_tot   = 1'b1;
        end
      end
      rdsa_pkg::OP_RM_SPECIAL: begin
        if (!ihit_r) begin
          dec_st = rdsa_pkg::ST_MISSING;
        end else begin
          dec_iwe = 1'b1;
          dec_tot = 1'b1;
          dec_sub = 1'b1;
        end
      end
      default: dec_st = rdsa_pkg::ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rdsa_pkg::S_IDLE: begin
        if (start) begin
          if (in_item.op == rdsa_pkg::OP_CLEAR) begin
            state_nxt = rdsa_pkg::S_CLR;
          end else if (in_item.op inside {rdsa_pkg::OP_ADD_FILE, rdsa_pkg::OP_RM_FILE}) begin
            state_nxt = rdsa_pkg::S_KSCAN;
          end else if (in_item.op inside {rdsa_pkg::OP_ADD_SPECIAL,
                                          rdsa_pkg::OP_RM_SPECIAL}) begin
            state_nxt = rdsa_pkg::S_ISCAN;
          end else begin
            state_nxt = rdsa_pkg::S_DONE;
          end
        end
      end
      rdsa_pkg::S_CLR: begin
        if (cnt_r == CEND) begin
          state_nxt = emit_r ? rdsa_pkg::S_DONE : rdsa_pkg::S_IDLE;
        end
      end
      rdsa_pkg::S_KSCAN: if (cnt_r == KEND) state_nxt = rdsa_pkg::S_ISCAN;
      rdsa_pkg::S_ISCAN: if (cnt_r == IEND) state_nxt = rdsa_pkg::S_DEC;
      rdsa_pkg::S_DEC:   state_nxt = dec_tot ? rdsa_pkg::S_DIV : rdsa_pkg::S_DONE;
      rdsa_pkg::S_DIV: begin
        if (dph_r && (dcnt_r == DCW'(NDG - 1))) state_nxt = rdsa_pkg::S_RND;
      end
      rdsa_pkg::S_RND:   state_nxt = rdsa_pkg::S_TOT;
      rdsa_pkg::S_TOT:   state_nxt = rdsa_pkg::S_DONE;
      rdsa_pkg::S_DONE:  state_nxt = rdsa_pkg::S_IDLE;
      default:           state_nxt = rdsa_pkg::S_IDLE;
    endcase
  end

  // shared divider: one 16-bit quotient digit per estimate and correction pair
  // the first step estimates the digit by reciprocal, the second corrects it up by one if needed
  assign div_v    = {rem_r, dq_r[DQW-1 -: DGW]};
  assign div_prod = PW'(div_v) * PW'(BREC);
  assign div_qb   = (VW+1)'(qe_r) * (VW+1)'(BDIV);
  assign div_rr   = {1'b0, div_v} - div_qb;
  assign div_fix  = (div_rr >= (VW+1)'(BDIV));
  assign blk_raw  = {1'b0, dq_r} + (DQW+1)'(rem_r != '0);
  assign bsum     = {1'b0, bytes_r} + (rdsa_pkg::BYTES_W+1)'(acc_r);
  assign ksum     = {1'b0, blocks_r} + {1'b0, blk_r};

  // outputs and datapath
  always_comb begin
    req_nxt        = req_r;
    out_nxt        = out_r;
    out_valid_nxt  = 1'b0;
    cnt_nxt        = cnt_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = cnt_r;
    emit_nxt       = emit_r;
    kmatch_nxt     = kmatch_r;
    kmatch_idx_nxt = kmatch_idx_r;
    kfree_nxt      = kfree_r;
    kfree_idx_nxt  = kfree_idx_r;
    ihit_nxt       = ihit_r;
    ihit_idx_nxt   = ihit_idx_r;
    kcnt_nxt       = kcnt_r;
    ksize_nxt      = ksize_r;
    st_nxt         = st_r;
    acc_nxt        = acc_r;
    sub_nxt        = sub_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    qe_nxt         = qe_r;
    dph_nxt        = dph_r;
    dcnt_nxt       = dcnt_r;
    blk_nxt        = blk_r;
    bytes_nxt      = bytes_r;
    blocks_nxt     = blocks_r;
    k_raddr        = cnt_r[KAW-1:0];
    i_raddr        = cnt_r[IAW-1:0];
    k_we           = 1'b0;
    i_we           = 1'b0;
    k_waddr        = dec_kaddr;
    i_waddr        = ihit_idx_r;
    k_wdata        = dec_kdata;
    i_wdata        = dec_idata;
    case (state_r)
      rdsa_pkg::S_IDLE: begin
        if (start) begin
          req_nxt    = in_item;
          cnt_nxt    = '0;
          kmatch_nxt = 1'b0;
          kfree_nxt  = 1'b0;
          ihit_nxt   = 1'b0;
          st_nxt     = rdsa_pkg::ST_OK;
          if (in_item.op == rdsa_pkg::OP_CLEAR) begin
            emit_nxt   = 1'b1;
            bytes_nxt  = '0;
            blocks_nxt = '0;
          end
        end
      end
      rdsa_pkg::S_CLR: begin
        k_waddr = cnt_r[KAW-1:0];
        i_waddr = cnt_r[IAW-1:0];
        k_wdata = '0;
        i_wdata = '0;
        k_we    = (cnt_r < KEND);
        i_we    = (cnt_r < IEND);
        cnt_nxt = cnt_r + SCW'(1);
      end
      rdsa_pkg::S_KSCAN: begin
        chk_v_nxt = (cnt_r < KEND);
        cnt_nxt   = (cnt_r == KEND) ? '0 : cnt_r + SCW'(1);
        if (chk_v_r) begin
          if (kq_v && (kq_key == req_r.inode_key) && !kmatch_r) begin
            kmatch_nxt     = 1'b1;
            kmatch_idx_nxt = chk_idx_r[KAW-1:0];
            kcnt_nxt       = kq_cnt;
            ksize_nxt      = kq_size;
          end
          if (!kq_v && !kfree_r) begin
            kfree_nxt     = 1'b1;
            kfree_idx_nxt = chk_idx_r[KAW-1:0];
          end
        end
      end
      rdsa_pkg::S_ISCAN: begin
        chk_v_nxt = (cnt_r < IEND);
        cnt_nxt   = cnt_r + SCW'(1);
        if (chk_v_r && i_cond && !ihit_r) begin
          ihit_nxt     = 1'b1;
          ihit_idx_nxt = chk_idx_r[IAW-1:0];
        end
      end
      rdsa_pkg::S_DEC: begin
        k_we     = dec_kwe;
        i_we     = dec_iwe;
        st_nxt   = dec_st;
        acc_nxt  = dec_acc;
        sub_nxt  = dec_sub;
        dq_nxt   = DQW'(dec_acc);
        rem_nxt  = '0;
        dph_nxt  = 1'b0;
        dcnt_nxt = '0;
      end
      rdsa_pkg::S_DIV: begin
        if (!dph_r) begin
          qe_nxt  = div_prod[32 +: DGW];
          dph_nxt = 1'b1;
        end else begin
          rem_nxt  = div_fix ? DGW'(div_rr - (VW+1)'(BDIV)) : div_rr[DGW-1:0];
          dq_nxt   = {dq_r[DQW-DGW-1:0], (div_fix ? qe_r + DGW'(1) : qe_r)};
          dph_nxt  = 1'b0;
          dcnt_nxt = dcnt_r + DCW'(1);
        end
      end
      rdsa_pkg::S_RND: begin
        blk_nxt = (blk_raw > (DQW+1)'(rdsa_pkg::BLOCKS_MAX)) ? rdsa_pkg::BLOCKS_MAX
                                                             : blk_raw[rdsa_pkg::BLOCKS_W-1:0];
      end
      rdsa_pkg::S_TOT: begin
        if (sub_r) begin
          bytes_nxt  = (rdsa_pkg::BYTES_W'(acc_r) > bytes_r) ? '0
                                                             : bytes_r - rdsa_pkg::BYTES_W'(acc_r);
          blocks_nxt = (blk_r > blocks_r) ? '0 : blocks_r - blk_r;
        end else begin
          bytes_nxt  = bsum[rdsa_pkg::BYTES_W] ? rdsa_pkg::BYTES_MAX
                                               : bsum[rdsa_pkg::BYTES_W-1:0];
          blocks_nxt = ksum[rdsa_pkg::BLOCKS_W] ? rdsa_pkg::BLOCKS_MAX
                                                : ksum[rdsa_pkg::BLOCKS_W-1:0];
        end
      end
      rdsa_pkg::S_DONE: begin
        out_valid_nxt = 1'b1;
        out_nxt       = '{total_bytes: bytes_r, total_blocks: blocks_r, status: st_r};
        emit_nxt      = 1'b0;
      end
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdsa_pkg::S_CLR;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      bytes_r     <= '0;
      blocks_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      bytes_r     <= bytes_nxt;
      blocks_r    <= blocks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    out_r        <= out_nxt;
    chk_idx_r    <= chk_idx_nxt;
    kmatch_r     <= kmatch_nxt;
    kmatch_idx_r <= kmatch_idx_nxt;
    kfree_r      <= kfree_nxt;
    kfree_idx_r  <= kfree_idx_nxt;
    ihit_r       <= ihit_nxt;
    ihit_idx_r   <= ihit_idx_nxt;
    kcnt_r       <= kcnt_nxt;
    ksize_r      <= ksize_nxt;
    st_r         <= st_nxt;
    acc_r        <= acc_nxt;
    sub_r        <= sub_nxt;
    dq_r         <= dq_nxt;
    rem_r        <= rem_nxt;
    qe_r         <= qe_nxt;
    dph_r        <= dph_nxt;
    dcnt_r       <= dcnt_nxt;
    blk_r        <= blk_nxt;
  end

  assign busy       = (state_r != rdsa_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // an accepted op always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted op did not start");

  // one strobe per op, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // divider never runs past the last digit
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rdsa_pkg::S_DIV) |-> (dcnt_r < DCW'(NDG))) else $error("divider overrun");

  // a strobe comes only from the done state
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == rdsa_pkg::S_DONE)) else $error("stray result strobe");

endmodule

/* bench/dedup_total_checker.sv */
// checker: watches both channels, predicts the totals and compares every result
module dedup_total_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  rdsa_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  rdsa_pkg::out_item_t out_result,
  output int                  errors,
  output int                  pending
);

  localparam int KEYS  = rdsa_pkg::KEY_SLOTS_DEF;
  localparam int ITEMS = rdsa_pkg::ITEM_SLOTS_DEF;
  localparam int SZW   = rdsa_pkg::SIZE_W;
  localparam int BYW   = rdsa_pkg::BYTES_W;
  localparam int BKW   = rdsa_pkg::BLOCKS_W;

  logic                        kvalid [KEYS];
  logic [rdsa_pkg::KEY_W-1:0]  kval   [KEYS];
  int unsigned                 kcount [KEYS];
  logic [SZW-1:0]              ksize  [KEYS];

  logic                        ivalid [ITEMS];
  logic                        ispec  [ITEMS];
  logic [rdsa_pkg::ID_W-1:0]   iid    [ITEMS];
  int                          islot  [ITEMS];

  logic [BYW-1:0] byte_sum;
  logic [BKW-1:0] block_sum;

  rdsa_pkg::out_item_t expected_totals[$];

  assign pending = expected_totals.size();

  task automatic wipe_tables();
    for (int i = 0; i < KEYS; i++) begin
      kvalid[i] = 1'b0;
      kcount[i] = 0;
      ksize[i]  = '0;
      kval[i]   = '0;
    end
    for (int i = 0; i < ITEMS; i++) begin
      ivalid[i] = 1'b0;
      ispec[i]  = 1'b0;
      iid[i]    = '0;
      islot[i]  = 0;
    end
    byte_sum  = '0;
    block_sum = '0;
  endtask

  function automatic logic [BKW-1:0] size_to_blocks(logic [SZW-1:0] sz);
    logic [SZW:0] r;
    r = ({1'b0, sz} + (SZW+1)'(rdsa_pkg::BLOCK_BYTES_DEF - 1)) /
        (SZW+1)'(rdsa_pkg::BLOCK_BYTES_DEF);
    return BKW'(r);
  endfunction

  task automatic totals_up(logic [SZW-1:0] sz);
    logic [BYW:0] b;
    logic [BKW:0] k;
    b = {1'b0, byte_sum} + (BYW+1)'(sz);
    k = {1'b0, block_sum} + {1'b0, size_to_blocks(sz)};
    byte_sum  = b[BYW] ? rdsa_pkg::BYTES_MAX : b[BYW-1:0];
    block_sum = k[BKW] ? rdsa_pkg::BLOCKS_MAX : k[BKW-1:0];
  endtask

  task automatic totals_down(logic [SZW-1:0] sz);
    logic [BKW-1:0] k;
    k = size_to_blocks(sz);
    byte_sum  = (BYW'(sz) > byte_sum) ? '0 : byte_sum - BYW'(sz);
    block_sum = (k > block_sum) ? '0 : block_sum - k;
  endtask

  function automatic int lowest_free_item();
    for (int i = 0; i < ITEMS; i++) if (!ivalid[i]) return i;
    return -1;
  endfunction

  function automatic int key_lookup(logic [rdsa_pkg::KEY_W-1:0] key);
    for (int i = 0; i < KEYS; i++) if (kvalid[i] && kval[i] == key) return i;
    return -1;
  endfunction

  function automatic int lowest_free_key();
    for (int i = 0; i < KEYS; i++) if (!kvalid[i]) return i;
    return -1;
  endfunction

  function automatic int item_lookup(logic [rdsa_pkg::ID_W-1:0] id, logic spec, int slot);
    for (int i = 0; i < ITEMS; i++)
      if (ivalid[i] && iid[i] == id && ispec[i] == spec && (spec || islot[i] == slot))
        return i;
    return -1;
  endfunction

  task automatic apply_op(input rdsa_pkg::in_item_t x, output rdsa_pkg::out_item_t r);
    int it;
    int ks;
    logic [1:0] st;
    st = rdsa_pkg::ST_OK;
    case (x.op)
      rdsa_pkg::OP_ADD_FILE: begin
        it = lowest_free_item();
        ks = key_lookup(x.inode_key);
        if (ks < 0) ks = lowest_free_key();
        if (it < 0 || ks < 0) begin
          st = rdsa_pkg::ST_FULL;
        end else begin
          if (!kvalid[ks] || kcount[ks] == 0) begin
            kvalid[ks] = 1'b1;
            kval[ks]   = x.inode_key;
            kcount[ks] = 0;
            ksize[ks]  = x.item_size;
            totals_up(x.item_size);
          end
          kcount[ks]++;
          ivalid[it] = 1'b1;
          ispec[it]  = 1'b0;
          iid[it]    = x.item_id;
          islot[it]  = ks;
        end
      end
      rdsa_pkg::OP_RM_FILE: begin
        ks = key_lookup(x.inode_key);
        it = (ks < 0) ? -1 : item_lookup(x.item_id, 1'b0, ks);
        if (it < 0) begin
          st = rdsa_pkg::ST_MISSING;
        end else begin
          if (x.item_size != ksize[ks]) st = rdsa_pkg::ST_MISMATCH;
          ivalid[it] = 1'b0;
          if (kcount[ks] > 0) kcount[ks]--;
          if (kcount[ks] == 0) begin
            totals_down(ksize[ks]);
            kvalid[ks] = 1'b0;
          end
        end
      end
      rdsa_pkg::OP_ADD_SPECIAL: begin
        it = lowest_free_item();
        if (it < 0) begin
          st = rdsa_pkg::ST_FULL;
        end else begin
          totals_up(x.item_size);
          ivalid[it] = 1'b1;
          ispec[it]  = 1'b1;
          iid[it]    = x.item_id;
          islot[it]  = 0;
        end
      end
      rdsa_pkg::OP_RM_SPECIAL: begin
        it = item_lookup(x.item_id, 1'b1, 0);
        if (it < 0) begin
          st = rdsa_pkg::ST_MISSING;
        end else begin
          ivalid[it] = 1'b0;
          totals_down(x.item_size);
        end
      end
      rdsa_pkg::OP_CLEAR: wipe_tables();
      default: ;
    endcase
    r.total_bytes  = byte_sum;
    r.total_blocks = block_sum;
    r.status       = st;
  endtask

  always @(posedge clk) begin
    rdsa_pkg::out_item_t want;
    if (!rst_n) begin
      wipe_tables();
      expected_totals.delete();
    end else begin
      // input transfer: predict now, the result follows later
      if (start && !busy) begin
        apply_op(in_item, want);
        expected_totals.push_back(want);
      end
      if (out_valid) begin
        if (expected_totals.size() == 0) begin
          $error("result with no transfer waiting");
          errors <= errors + 1;
        end else begin
          want = expected_totals.pop_front();
          if (out_result.total_bytes !== want.total_bytes ||
              out_result.total_blocks !== want.total_blocks ||
              out_result.status !== want.status) begin
            if (out_result.total_bytes !== want.total_bytes)
              $error("total_bytes expected %0h got %0h",
                     want.total_bytes, out_result.total_bytes);
            if (out_result.total_blocks !== want.total_blocks)
              $error("total_blocks expected %0h got %0h",
                     want.total_blocks, out_result.total_blocks);
            if (out_result.status !== want.status)
              $error("status expected %0d got %0d", want.status, out_result.status);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

/* bench/testbench.sv */
// testbench top: clock, reset, stimulus, watchdog and verdict for the accumulator
module testbench;

  localparam int SZW = rdsa_pkg::SIZE_W;
  localparam int KYW = rdsa_pkg::KEY_W;
  localparam int IDW = rdsa_pkg::ID_W;
  localparam logic [SZW-1:0] SIZE_TOP = '1;
  localparam int STALL_LIMIT = 20000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  rdsa_pkg::in_item_t  in_item;
  logic                out_valid;
  rdsa_pkg::out_item_t out_result;
  int                  errors;
  int                  pending;

  // gaps between transfers are allowed until the tail of the run
  logic quiet;
  int   stall_cycles;

  // small pools so that adds and removes meet each other
  logic [KYW-1:0] key_pool  [8];
  logic [SZW-1:0] size_pool [8];

  refcounted_dedup_size_accumulator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_result(out_result)
  );

  dedup_total_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_result(out_result),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: any stretch with no transfer on either channel that is too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("refcounted_dedup_size_accumulator regression: fail");
        $finish;
      end
    end
  end

  // present one item and return at the edge where it is transferred;
  // busy only moves on rising edges, so the falling edge sees its next value
  task automatic send(logic [2:0] op, logic [IDW-1:0] id,
                      logic [KYW-1:0] key, logic [SZW-1:0] sz);
    in_item <= '{op: op, item_id: id, inode_key: key, item_size: sz};
    start   <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    // random idle burst after the transfer
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [SZW-1:0] any_size();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SIZE_TOP;
      2:       return SZW'($urandom_range(0, 5000));
      default: return SZW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [IDW-1:0] any_id();
    return ($urandom_range(0, 4) == 0) ? $urandom : IDW'($urandom_range(0, 7));
  endfunction

  task automatic fresh_pools();
    for (int i = 0; i < 8; i++) begin
      key_pool[i]  = {$urandom, $urandom};
      size_pool[i] = any_size();
    end
  endtask

  // one random item, mostly well-formed add/remove traffic on the pools
  task automatic random_item();
    int k;
    int pick;
    k    = $urandom_range(0, 7);
    pick = $urandom_range(0, 99);
    if (pick < 35)
      send(rdsa_pkg::OP_ADD_FILE, any_id(), key_pool[k], size_pool[k]);
    else if (pick < 60)
      send(rdsa_pkg::OP_RM_FILE, any_id(), key_pool[k],
           ($urandom_range(0, 5) == 0) ? any_size() : size_pool[k]);
    else if (pick < 72)
      send(rdsa_pkg::OP_ADD_SPECIAL, any_id(), {$urandom, $urandom}, any_size());
    else if (pick < 82)
      send(rdsa_pkg::OP_RM_SPECIAL, any_id(), {$urandom, $urandom}, any_size());
    else if (pick < 88)
      send(rdsa_pkg::OP_ADD_FILE, any_id(), {$urandom, $urandom}, any_size());
    else if (pick < 92)
      send(rdsa_pkg::OP_RM_FILE, $urandom, {$urandom, $urandom}, any_size());
    else if (pick < 95)
      send(3'($urandom_range(5, 7)), $urandom, {$urandom, $urandom}, any_size());
    else if (pick < 97)
      send(rdsa_pkg::OP_CLEAR, $urandom, {$urandom, $urandom}, any_size());
    else
      send(3'($urandom_range(0, 7)), $urandom, {$urandom, $urandom},
           SZW'({$urandom, $urandom}));
  endtask

  initial begin
    start        = 1'b0;
    in_item      = '0;
    rst_n        = 1'b0;
    quiet        = 1'b0;
    fresh_pools();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: unused codes, unknown removes, block edges, refs and mismatch
    send(3'd5, '1, '1, SIZE_TOP);
    send(3'd6, '0, '0, '0);
    send(3'd7, 32'h5a5a_a5a5, 64'h1234, 44'd7);
    send(rdsa_pkg::OP_RM_FILE, 32'd1, 64'hdead, 44'd10);
    send(rdsa_pkg::OP_RM_SPECIAL, 32'd1, 64'h0, 44'd10);
    send(rdsa_pkg::OP_ADD_FILE, 32'd1, 64'h0, 44'd0);
    send(rdsa_pkg::OP_ADD_FILE, 32'd2, 64'h0, 44'd99);
    send(rdsa_pkg::OP_RM_FILE, 32'd1, 64'h0, 44'd99);
    send(rdsa_pkg::OP_RM_FILE, 32'd2, 64'h0, 44'd0);
    send(rdsa_pkg::OP_ADD_FILE, 32'd3, 64'h1, 44'd1);
    send(rdsa_pkg::OP_ADD_FILE, 32'd4, 64'h2, 44'd2048);
    send(rdsa_pkg::OP_ADD_FILE, 32'd5, 64'h3, 44'd2049);
    send(rdsa_pkg::OP_ADD_FILE, '1, '1, SIZE_TOP);
    send(rdsa_pkg::OP_ADD_FILE, '1, '1, SIZE_TOP);
    send(rdsa_pkg::OP_RM_FILE, '1, '1, SIZE_TOP);
    send(rdsa_pkg::OP_RM_FILE, '1, '1, SIZE_TOP);
    send(rdsa_pkg::OP_RM_FILE, '1, '1, SIZE_TOP);
    send(rdsa_pkg::OP_ADD_SPECIAL, '0, '0, SIZE_TOP);
    send(rdsa_pkg::OP_RM_SPECIAL, '0, '0, 44'd0);
    send(rdsa_pkg::OP_RM_SPECIAL, '0, '0, 44'd5);
    send(rdsa_pkg::OP_CLEAR, '0, '0, '0);
    send(rdsa_pkg::OP_RM_FILE, 32'd3, 64'h1, 44'd1);

    // hold off until every result is back
    drain();

    for (int n = 0; n < 80; n++) random_item();

    // saturate both totals, then take them down past zero
    for (int n = 0; n < 18; n++) send(rdsa_pkg::OP_ADD_SPECIAL, 32'd9, '0, SIZE_TOP);
    for (int n = 0; n < 20; n++) send(rdsa_pkg::OP_RM_SPECIAL, 32'd9, '0, SIZE_TOP);
    send(rdsa_pkg::OP_CLEAR, '0, '0, '0);
    fresh_pools();

    // fill the key table with distinct keys, then the item table with specials
    for (int n = 0; n < 258; n++)
      send(rdsa_pkg::OP_ADD_FILE, $urandom, {$urandom, $urandom}, any_size());
    for (int n = 0; n < 258; n++)
      send(rdsa_pkg::OP_ADD_SPECIAL, $urandom, {$urandom, $urandom}, any_size());
    for (int n = 0; n < 20; n++) random_item();
    send(rdsa_pkg::OP_CLEAR, '0, '0, '0);
    fresh_pools();

    // tail without idle gaps
    quiet = 1'b1;
    for (int n = 0; n < 40; n++) random_item();

    drain();
    repeat (1000) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("refcounted_dedup_size_accumulator regression: pass");
    else
      $display("refcounted_dedup_size_accumulator regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/rdsa_pkg.sv
rtl/rdsa_ram.sv
rtl/refcounted_dedup_size_accumulator.sv
bench/dedup_total_checker.sv
bench/testbench.sv
